// File: rtl/brf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Types, constants and index helpers shared by the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DEPTH      = 256;
  localparam int MAX_BURST  = 64;
  localparam int RING_LIMIT = (DEPTH < 256) ? DEPTH : 256;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 8;
  localparam int SIZE_W = 9;
  localparam int CMD_W  = 3;
  localparam int CNT_W  = $clog2(MAX_BURST + 1);
  localparam int RAM_AW = $clog2(DEPTH);

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(RING_LIMIT);
  localparam logic [SIZE_W-1:0] BURST_CAP  = SIZE_W'(MAX_BURST);

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BURST   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK_RD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADV_RD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_WR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ADV_WR  = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic [SIZE_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              accepted;
    logic [IDX_W-1:0]  start_index;
    logic [IDX_W-1:0]  span_length;
    logic [IDX_W-1:0]  fill_level;
    logic [IDX_W-1:0]  free_count;
    logic              last;
  } out_item_t;

  // ring size and index clear from the register side, plus output-slot status
  typedef struct packed {
    logic              clear;
    logic [SIZE_W-1:0] size;
    logic              slot_free;
  } ring_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST_READ,
    ST_BURST_SEND
  } seq_state_t;

  function automatic logic [IDX_W-1:0] ring_fill(input logic [IDX_W-1:0] w,
                                                 input logic [IDX_W-1:0] r,
                                                 input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] d;
    if (w >= r) d = {1'b0, w} - {1'b0, r};
    else        d = s + {1'b0, w} - {1'b0, r};
    return d[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_free(input logic [IDX_W-1:0] w,
                                                 input logic [IDX_W-1:0] r,
                                                 input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] d;
    if (r > w) d = {1'b0, r} - {1'b0, w} - SIZE_W'(1);
    else       d = s - SIZE_W'(1) - ({1'b0, w} - {1'b0, r});
    return d[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/brf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/brf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_seq
// Command sequencer: ring indices, byte store access and result building.
// ----------------------------------------------------------------------------
module brf_seq
  import brf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ring_ctl_t ring,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      res_valid,
  output out_item_t res
);

  seq_state_t        state, state_next;
  logic [IDX_W-1:0]  wr_idx, wr_idx_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic [CNT_W-1:0]  cnt, cnt_next;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [IDX_W-1:0]  wr_inc, rd_inc, adv_base, adv_idx, fill_cur, free_cur;
  logic [SIZE_W-1:0] adv_sum, tend, burst_len, len_capped;
  logic              too_far;

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (RAM_AW'(wr_idx)),
    .wdata (in_data.data_byte),
    .re    (ram_re),
    .raddr (RAM_AW'(ram_raddr)),
    .rdata (ram_rdata)
  );

  always_comb begin
    wr_inc   = (({1'b0, wr_idx} + SIZE_W'(1)) == ring.size) ? '0 : wr_idx + IDX_W'(1);
    rd_inc   = (({1'b0, rd_idx} + SIZE_W'(1)) == ring.size) ? '0 : rd_idx + IDX_W'(1);
    fill_cur = ring_fill(wr_idx, rd_idx, ring.size);
    free_cur = ring_free(wr_idx, rd_idx, ring.size);
    tend     = ring.size - {1'b0, wr_idx};
    too_far  = in_data.length > ring.size;
    adv_base = (in_data.command == CMD_ADV_RD) ? rd_idx : wr_idx;
    // sum stays below twice the size, so one subtract wraps it
    adv_sum  = {1'b0, adv_base} + in_data.length;
    adv_idx  = (adv_sum >= ring.size) ? IDX_W'(adv_sum - ring.size) : adv_sum[IDX_W-1:0];
    len_capped = (in_data.length > BURST_CAP) ? BURST_CAP : in_data.length;
    burst_len  = (len_capped > {1'b0, fill_cur}) ? {1'b0, fill_cur} : len_capped;
  end

  always_comb begin
    state_next  = state;
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    cnt_next    = cnt;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    unique case (state)
      ST_IDLE: begin
        in_ready = ring.slot_free;
        if (in_valid && ring.slot_free) begin
          res.last = 1'b1;
          res_valid = 1'b1;
          unique case (in_data.command)
            CMD_PUSH: begin
              if (wr_inc != rd_idx) begin
                ram_we       = 1'b1;
                wr_idx_next  = wr_inc;
                res.accepted = 1'b1;
              end
            end
            CMD_BURST: begin
              if (burst_len != '0) begin
                res_valid  = 1'b0;
                cnt_next   = CNT_W'(burst_len);
                state_next = ST_BURST_READ;
              end
            end
            CMD_PEEK_RD: begin
              res.accepted    = 1'b1;
              res.start_index = rd_idx;
              if (wr_idx == rd_idx)     res.span_length = '0;
              else if (wr_idx > rd_idx) res.span_length = wr_idx - rd_idx;
              else                      res.span_length = IDX_W'(ring.size - {1'b0, rd_idx});
            end
            CMD_PEEK_WR: begin
              res.accepted    = 1'b1;
              res.start_index = wr_idx;
              res.span_length = ({1'b0, free_cur} < tend) ? free_cur : tend[IDX_W-1:0];
            end
            CMD_ADV_RD, CMD_ADV_WR: begin
              if (!too_far) begin
                res.accepted = 1'b1;
                if (in_data.command == CMD_ADV_RD) rd_idx_next = adv_idx;
                else                               wr_idx_next = adv_idx;
              end
            end
            default: begin
              res.accepted = 1'b0;
            end
          endcase
        end
      end
      ST_BURST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_BURST_SEND;
      end
      ST_BURST_SEND: begin
        if (ring.slot_free) begin
          res_valid      = 1'b1;
          res.read_byte  = ram_rdata;
          res.byte_valid = 1'b1;
          res.accepted   = 1'b1;
          res.last       = (cnt == CNT_W'(1));
          rd_idx_next    = rd_inc;
          cnt_next       = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            // fetch the following byte into the store's read register for the next send
            ram_re    = 1'b1;
            ram_raddr = rd_inc;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.fill_level = ring_fill(wr_idx_next, rd_idx_next, ring.size);
    res.free_count = ring_free(wr_idx_next, rd_idx_next, ring.size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      wr_idx <= '0;
      rd_idx <= '0;
      cnt    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (ring.clear) begin
        wr_idx <= '0;
        rd_idx <= '0;
      end else begin
        wr_idx <= wr_idx_next;
        rd_idx <= rd_idx_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_wr_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wr_idx} < ring.size)
    else $error("write index outside ring");

  a_rd_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, rd_idx} < ring.size)
    else $error("read index outside ring");

  a_no_push_in_burst: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE)
    else $error("store written during a burst");

  a_burst_count: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> cnt != '0)
    else $error("burst running with zero count");

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.byte_valid && res.last) |=> state == ST_IDLE)
    else $error("burst continues past its last byte");
`endif

endmodule

// File: rtl/byte_ring_fifo_dma_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_dma_window
// Byte ring FIFO with push, read burst, window peek and index advance.
// ----------------------------------------------------------------------------
// Push, peek, advance and unknown commands give a single result each: the
// result is built in the cycle the command is taken and sits in the output
// register, and the next command is taken as soon as that register is free.
// A read burst keeps the input closed until its last byte is sent: first
// a read of the byte store (one synchronous RAM with a registered read),
// then one byte per cycle while the output slot is free, each prefetching
// the next. A burst that finds nothing gives a single empty result. Output
// back-pressure stretches all of these. Writing the size register clears
// both indices; the stored bytes stay. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module byte_ring_fifo_dma_window
  import brf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] size_next;
  ring_ctl_t         ring;
  logic              res_valid;
  out_item_t         res;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < SIZE_MIN)      size_next = SIZE_MIN;
    else if (cfg_data > SIZE_MAX) size_next = SIZE_MAX;
    else                          size_next = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SIZE_MAX;
    end else if (cfg_valid) begin
      size <= size_next;
    end
  end

  assign ring.clear     = cfg_valid;
  assign ring.size      = size;
  assign ring.slot_free = !out_valid || out_ready;

  brf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .ring      (ring),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register; the sequencer only offers a result when it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule

// File: tb/byte_ring_fifo_dma_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_dma_window_tb
// Self-checking bench for the byte ring FIFO. A scoreboard keeps its own copy
// of the ring, indices and size, predicts every result of each command taken
// and checks the result stream in order. Directed corner cases come first,
// then random command mixes over several ring sizes and handshake patterns.
// ----------------------------------------------------------------------------
module byte_ring_fifo_dma_window_tb;
  import brf_pkg::*;

  // command codes with no function in the block
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam int SHOW_MAX     = 10;
  localparam int DRAIN_CYCLES = 8;

  class ring_scoreboard;
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    bit                slot_written [DEPTH];
    int unsigned       size_reg;
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    out_item_t         pending_results [$];
    int                errors;
    int                reported;

    function new();
      size_reg = RING_LIMIT;
      wr_ptr   = 0;
      rd_ptr   = 0;
      errors   = 0;
      reported = 0;
      foreach (slot_written[i]) slot_written[i] = 1'b0;
    endfunction

    function int unsigned ring_len();
      if (size_reg < SIZE_MIN) return SIZE_MIN;
      if (size_reg > SIZE_MAX) return SIZE_MAX;
      return size_reg;
    endfunction

    function int unsigned fill_level();
      if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
      return ring_len() + wr_ptr - rd_ptr;
    endfunction

    function int unsigned free_space();
      if (rd_ptr > wr_ptr) return rd_ptr - wr_ptr - 1;
      return ring_len() - 1 - (wr_ptr - rd_ptr);
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      size_reg = value;
      wr_ptr   = 0;
      rd_ptr   = 0;
    endfunction

    // Trim a burst so it never reaches a slot that has not been written yet.
    function int unsigned safe_burst_len(int unsigned len);
      int unsigned n;
      int unsigned k;
      int unsigned idx;
      n   = len;
      k   = 0;
      idx = rd_ptr;
      if (n > MAX_BURST) n = MAX_BURST;
      if (n > fill_level()) n = fill_level();
      while (k < n && slot_written[idx]) begin
        k++;
        idx = (idx + 1) % ring_len();
      end
      return (k < n) ? k : len;
    endfunction

    function void queue_result(int unsigned rb, bit vld, bit acc, int unsigned start,
                               int unsigned span, bit lst);
      out_item_t r;
      r.read_byte   = BYTE_W'(rb);
      r.byte_valid  = vld;
      r.accepted    = acc;
      r.start_index = IDX_W'(start);
      r.span_length = IDX_W'(span);
      r.fill_level  = IDX_W'(fill_level());
      r.free_count  = IDX_W'(free_space());
      r.last        = lst;
      pending_results.push_back(r);
    endfunction

    function void note_command(in_item_t cmd);
      int unsigned       s;
      int unsigned       n;
      int unsigned       f;
      int unsigned       span;
      logic [BYTE_W-1:0] rb;
      s = ring_len();
      case (cmd.command)
        CMD_PUSH: begin
          if ((wr_ptr + 1) % s == rd_ptr) begin
            queue_result(0, 0, 0, 0, 0, 1);
          end else begin
            ring_mem[wr_ptr]     = cmd.data_byte;
            slot_written[wr_ptr] = 1'b1;
            wr_ptr = (wr_ptr + 1) % s;
            queue_result(0, 0, 1, 0, 0, 1);
          end
        end
        CMD_BURST: begin
          n = cmd.length;
          f = fill_level();
          if (n > MAX_BURST) n = MAX_BURST;
          if (n > f) n = f;
          if (n == 0) queue_result(0, 0, 0, 0, 0, 1);
          for (int unsigned k = 0; k < n; k++) begin
            rb     = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % s;
            queue_result(rb, 1, 1, 0, 0, k + 1 == n);
          end
        end
        CMD_PEEK_RD: begin
          if (wr_ptr == rd_ptr)     span = 0;
          else if (wr_ptr > rd_ptr) span = wr_ptr - rd_ptr;
          else                      span = s - rd_ptr;
          queue_result(0, 0, 1, rd_ptr, span, 1);
        end
        CMD_PEEK_WR: begin
          f    = free_space();
          span = (f < s - wr_ptr) ? f : s - wr_ptr;
          queue_result(0, 0, 1, wr_ptr, span, 1);
        end
        CMD_ADV_RD, CMD_ADV_WR: begin
          // too far: nothing moves; otherwise applied even past the other index
          if (cmd.length > s) begin
            queue_result(0, 0, 0, 0, 0, 1);
          end else begin
            if (cmd.command == CMD_ADV_RD) rd_ptr = (rd_ptr + cmd.length) % s;
            else                           wr_ptr = (wr_ptr + cmd.length) % s;
            queue_result(0, 0, 1, 0, 0, 1);
          end
        end
        default: begin
          queue_result(0, 0, 0, 0, 0, 1);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (reported < SHOW_MAX) begin
          reported++;
          $display("ERROR: %0t result with none pending: %h", $time, got);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.read_byte !== want.read_byte || got.byte_valid !== want.byte_valid ||
          got.accepted !== want.accepted || got.start_index !== want.start_index ||
          got.span_length !== want.span_length || got.fill_level !== want.fill_level ||
          got.free_count !== want.free_count || got.last !== want.last) begin
        errors++;
        if (reported < SHOW_MAX) begin
          reported++;
          $display("ERROR: %0t want rb=%h v=%b acc=%b st=%0d sp=%0d fill=%0d free=%0d last=%b",
                   $time, want.read_byte, want.byte_valid, want.accepted, want.start_index,
                   want.span_length, want.fill_level, want.free_count, want.last);
          $display("ERROR: %0t got  rb=%h v=%b acc=%b st=%0d sp=%0d fill=%0d free=%0d last=%b",
                   $time, got.read_byte, got.byte_valid, got.accepted, got.start_index,
                   got.span_length, got.fill_level, got.free_count, got.last);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;

  ring_scoreboard sb;
  int             in_gap_pct    = 11;
  int             out_stall_pct = 55;
  int             items_sent    = 0;

  byte_ring_fifo_dma_window u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_cmd(logic [CMD_W-1:0] op, logic [BYTE_W-1:0] data,
                          logic [SIZE_W-1:0] len);
    in_item_t item;
    item.command   = op;
    item.data_byte = data;
    item.length    = (op == CMD_BURST) ? SIZE_W'(sb.safe_burst_len(len)) : len;
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_command(item);
    items_sent++;
  endtask

  // stop sending and let every pending result out
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [SIZE_W-1:0] value);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_size(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    int unsigned       pick;
    int unsigned       roll;
    int unsigned       s;
    int unsigned       f;
    logic [SIZE_W-1:0] len;
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    s    = sb.ring_len();
    f    = sb.fill_level();
    len  = SIZE_W'($urandom);
    if (pick < 10) begin
      // producer run then a short drain burst
      repeat ($urandom_range(12, 3)) send_cmd(CMD_PUSH, BYTE_W'($urandom), SIZE_W'($urandom));
      send_cmd(CMD_BURST, BYTE_W'($urandom), SIZE_W'($urandom_range(16, 1)));
    end else if (pick < 40) begin
      send_cmd(CMD_PUSH, BYTE_W'($urandom), len);
    end else if (pick < 60) begin
      if (roll < 10)      len = '0;
      else if (roll > 25) len = SIZE_W'($urandom_range(f + 2, 1));
      send_cmd(CMD_BURST, BYTE_W'($urandom), len);
    end else if (pick < 68) begin
      send_cmd(CMD_PEEK_RD, BYTE_W'($urandom), len);
    end else if (pick < 76) begin
      send_cmd(CMD_PEEK_WR, BYTE_W'($urandom), len);
    end else if (pick < 94) begin
      // mostly DMA-like advances inside the window, some overruns, some too far
      if (roll < 55)      len = SIZE_W'($urandom_range((pick < 85) ? f : sb.free_space()));
      else if (roll < 85) len = SIZE_W'($urandom_range(s));
      else                len = SIZE_W'($urandom_range(511, s + 1));
      send_cmd((pick < 85) ? CMD_ADV_RD : CMD_ADV_WR, BYTE_W'($urandom), len);
    end else begin
      send_cmd((roll < 50) ? CMD_RSVD6 : CMD_RSVD7, BYTE_W'($urandom), len);
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random();
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full-size ring after reset
    send_cmd(CMD_BURST,   8'h00, 9'd0);
    send_cmd(CMD_PEEK_RD, 8'h00, 9'd0);
    send_cmd(CMD_PEEK_WR, 8'h00, 9'd0);
    send_cmd(CMD_RSVD6,   8'hFF, 9'h1FF);
    send_cmd(CMD_RSVD7,   8'h00, 9'd0);
    send_cmd(CMD_PUSH,    8'h00, 9'd0);
    send_cmd(CMD_PUSH,    8'hFF, 9'h1FF);
    send_cmd(CMD_PUSH,    8'hA5, 9'd0);
    send_cmd(CMD_PEEK_RD, 8'h00, 9'd0);
    send_cmd(CMD_BURST,   8'h00, 9'd0);
    send_cmd(CMD_BURST,   8'h00, 9'd1);
    send_cmd(CMD_ADV_RD,  8'h00, 9'd257);
    send_cmd(CMD_ADV_WR,  8'h00, 9'h1FF);
    send_cmd(CMD_ADV_WR,  8'h00, 9'd256);
    send_cmd(CMD_ADV_RD,  8'h00, 9'd256);
    send_cmd(CMD_BURST,   8'h00, 9'h1FF);

    // smallest ring: one byte fills it
    cfg_write(SIZE_W'(2));
    send_cmd(CMD_PUSH,    8'h3C, 9'd0);
    send_cmd(CMD_PUSH,    8'hC3, 9'd0);
    send_cmd(CMD_PEEK_WR, 8'h00, 9'd0);
    send_cmd(CMD_PEEK_RD, 8'h00, 9'd0);
    send_cmd(CMD_ADV_WR,  8'h00, 9'd3);
    send_cmd(CMD_ADV_RD,  8'h00, 9'd2);
    send_cmd(CMD_BURST,   8'h00, 9'd64);
    send_cmd(CMD_ADV_RD,  8'h00, 9'd1);
    send_cmd(CMD_PEEK_WR, 8'h00, 9'd0);

    // oversized write clamps to the full ring; fill deep enough for a capped burst
    cfg_write(9'h1FF);
    repeat (70) send_cmd(CMD_PUSH, BYTE_W'($urandom), SIZE_W'($urandom));
    send_cmd(CMD_BURST, 8'h00, 9'h1FF);
    run_random(10);

    in_gap_pct    = 55;
    out_stall_pct = 11;
    cfg_write(SIZE_W'(0));
    run_random(8);
    cfg_write(SIZE_W'(3));
    run_random(10);

    in_gap_pct    = 0;
    out_stall_pct = 0;
    cfg_write(SIZE_W'(256));
    run_random(12);
    cfg_write(SIZE_W'(1));
    run_random(5);
    cfg_write(SIZE_W'(37));
    run_random(10);

    wait_drain();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_seq.sv
rtl/byte_ring_fifo_dma_window.sv
tb/byte_ring_fifo_dma_window_tb.sv
